// ===== sv/bhmm_pkg.sv =====
// shared types, widths and constants for the binned hit mean map
package bhmm_pkg;

    parameter int BINS_DEFAULT = 200;

    localparam int POS_W      = 19;
    localparam int DIFF_W     = 20;
    localparam int AMP_W      = 12;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 20;
    localparam int SUM_W      = 32;
    localparam int WIDTH_W    = 16;
    localparam int MEAN_W     = 12;
    localparam int DVD_W      = 12;
    localparam int STEP_W     = $clog2(MEAN_W + 1);
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [MEAN_W-1:0]  MEAN_MAX  = '1;

    localparam logic [POS_W-1:0]   ORIGIN_RESET    = 19'h4F2C0;
    localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = 16'd2000;
    localparam logic [CNT_W-1:0]   THRESHOLD_RESET = 20'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_BIN_WIDTH,
        REG_COUNT_THRESHOLD
    } cfg_reg_t;

    typedef enum logic {
        OP_HIT,
        OP_READ
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_AXSET,
        S_DIV,
        S_DEND,
        S_ADDR,
        S_RD,
        S_UPD,
        S_MSET,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        DK_X,
        DK_Y,
        DK_MEAN
    } div_kind_t;

endpackage

// ===== sv/binned_hit_mean_map.sv =====
// Two-dimensional hit histogram: each hit is binned on x and y and adds its
// amplitude to that bin's saturating sum and count; a read returns a bin's
// count, and its truncated mean amplitude once the count exceeds count_threshold.
// One item is worked at a time. All divisions (the two bin indices and the
// mean) go through one shared restoring divider that makes one quotient bit
// per cycle; out-of-range items finish sooner than in-range ones.
// The sum/count store is a single-port-write memory of BINS*BINS words. After
// reset it is swept to zero one word per cycle, during which no input item is
// taken; configuration writes are taken at any time but must only be issued
// while the block is idle.
module binned_hit_mean_map #(
    parameter int BINS = bhmm_pkg::BINS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // op
    input  logic                               s_tuser,
    // pos_x, pos_y, amplitude, read_bin_x, read_bin_y
    input  logic [bhmm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // in_range, bin_x, bin_y, hit_count, mean_amplitude
    output logic [bhmm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bhmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bhmm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bhmm_pkg::*;

    localparam int DEPTH  = BINS * BINS;
    localparam int AW     = $clog2(DEPTH);
    localparam int QW     = $clog2(BINS);
    localparam int WORD_W = CNT_W + SUM_W;

    // configuration registers
    logic [POS_W-1:0]   origin_x_reg, origin_y_reg;
    logic [WIDTH_W-1:0] bin_width_reg;
    logic [CNT_W-1:0]   threshold_reg;

    // control
    state_t    state_reg, state_next;
    div_kind_t kind_reg, kind_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // working payload
    op_t               op_reg, op_next;
    logic [AMP_W-1:0]  amp_reg, amp_next;
    logic [DIFF_W-1:0] diff_x_reg, diff_x_next, diff_y_reg, diff_y_next;
    logic              ok_reg, ok_next;
    logic [IDX_W-1:0]  bx_reg, bx_next, by_reg, by_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // shared divider
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] divisor_reg, divisor_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W:0]   partial, trial;

    // memory
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // input fields
    logic [POS_W-1:0] in_pos_x, in_pos_y;
    logic [AMP_W-1:0] in_amp;
    logic [IDX_W-1:0] in_rbx, in_rby;

    // comb helpers
    logic [DIFF_W-1:0] axis_diff;
    logic [QW-1:0]     axis_q;
    logic [SUM_W-1:0]  rd_sum, upd_sum;
    logic [CNT_W-1:0]  rd_cnt;
    logic [SUM_W:0]    sum_ext;
    logic              out_free;

    assign in_pos_x = s_tdata[POS_W-1:0];
    assign in_pos_y = s_tdata[2*POS_W-1:POS_W];
    assign in_amp   = s_tdata[2*POS_W+AMP_W-1:2*POS_W];
    assign in_rbx   = s_tdata[2*POS_W+AMP_W+IDX_W-1:2*POS_W+AMP_W];
    assign in_rby   = s_tdata[2*POS_W+AMP_W+2*IDX_W-1:2*POS_W+AMP_W+IDX_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    assign rd_sum  = rd_data_reg[SUM_W-1:0];
    assign rd_cnt  = rd_data_reg[WORD_W-1:SUM_W];
    assign sum_ext = {1'b0, rd_sum} + (SUM_W+1)'(amp_reg);
    assign upd_sum = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

    assign axis_diff = (kind_reg == DK_Y) ? diff_y_reg : diff_x_reg;
    assign axis_q    = quo_reg[QW-1:0];
    assign out_free  = !m_tvalid_reg || m_tready;

    // one restoring division step
    assign partial = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial   = partial - {1'b0, divisor_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg  <= ORIGIN_RESET;
            origin_y_reg  <= ORIGIN_RESET;
            bin_width_reg <= BIN_WIDTH_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:        origin_x_reg  <= cfg_data[POS_W-1:0];
                REG_ORIGIN_Y:        origin_y_reg  <= cfg_data[POS_W-1:0];
                REG_BIN_WIDTH:       bin_width_reg <= cfg_data[WIDTH_W-1:0];
                REG_COUNT_THRESHOLD: threshold_reg <= cfg_data[CNT_W-1:0];
            endcase
        end
    end

    // sum/count store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        step_reg    <= step_next;
        op_reg      <= op_next;
        amp_reg     <= amp_next;
        diff_x_reg  <= diff_x_next;
        diff_y_reg  <= diff_y_next;
        ok_reg      <= ok_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        addr_reg    <= addr_next;
        sum_reg     <= sum_next;
        count_reg   <= count_next;
        mean_reg    <= mean_next;
        m_tdata_reg <= m_tdata_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        dvd_reg     <= dvd_next;
        quo_reg     <= quo_next;
    end

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        clr_addr_next = clr_addr_reg;
        step_next     = step_reg;
        op_next       = op_reg;
        amp_next      = amp_reg;
        diff_x_next   = diff_x_reg;
        diff_y_next   = diff_y_reg;
        ok_next       = ok_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        addr_next     = addr_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        mean_next     = mean_reg;
        m_tdata_next  = m_tdata_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        dvd_next      = dvd_reg;
        quo_next      = quo_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = {count_reg, sum_reg};

        unique case (state_reg)
            S_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = op_t'(s_tuser);
                    amp_next    = in_amp;
                    diff_x_next = {in_pos_x[POS_W-1], in_pos_x}
                                - {origin_x_reg[POS_W-1], origin_x_reg};
                    diff_y_next = {in_pos_y[POS_W-1], in_pos_y}
                                - {origin_y_reg[POS_W-1], origin_y_reg};
                    if (op_t'(s_tuser) == OP_READ) begin
                        bx_next = in_rbx;
                        by_next = in_rby;
                        ok_next = ({1'b0, in_rbx} < (IDX_W+1)'(BINS))
                               && ({1'b0, in_rby} < (IDX_W+1)'(BINS));
                        state_next = ok_next ? S_ADDR : S_OUT;
                    end else begin
                        ok_next    = 1'b1;
                        kind_next  = DK_X;
                        state_next = S_AXSET;
                    end
                end
            end
            S_AXSET: begin
                // quotient fits in QW bits only if diff >> QW is below the width
                if (axis_diff[DIFF_W-1]
                    || (DIFF_W'(axis_diff[DIFF_W-1:QW]) >= DIFF_W'(bin_width_reg))) begin
                    ok_next    = 1'b0;
                    state_next = S_OUT;
                end else begin
                    rem_next     = CNT_W'(axis_diff[DIFF_W-1:QW]);
                    dvd_next     = DVD_W'(axis_diff[QW-1:0]) << (DVD_W - QW);
                    divisor_next = CNT_W'(bin_width_reg);
                    quo_next     = '0;
                    step_next    = STEP_W'(QW);
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                dvd_next  = dvd_reg << 1;
                step_next = step_reg - 1'b1;
                if (!trial[CNT_W]) begin
                    rem_next = trial[CNT_W-1:0];
                    quo_next = {quo_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_next = partial[CNT_W-1:0];
                    quo_next = {quo_reg[DVD_W-2:0], 1'b0};
                end
                if (step_reg == STEP_W'(1)) begin
                    state_next = S_DEND;
                end
            end
            S_DEND: begin
                unique case (kind_reg)
                    DK_X, DK_Y: begin
                        if ({1'b0, axis_q} < (QW+1)'(BINS)) begin
                            if (kind_reg == DK_X) begin
                                bx_next    = IDX_W'(axis_q);
                                kind_next  = DK_Y;
                                state_next = S_AXSET;
                            end else begin
                                by_next    = IDX_W'(axis_q);
                                state_next = S_ADDR;
                            end
                        end else begin
                            ok_next    = 1'b0;
                            state_next = S_OUT;
                        end
                    end
                    DK_MEAN: begin
                        mean_next  = quo_reg[MEAN_W-1:0];
                        state_next = S_OUT;
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_ADDR: begin
                addr_next  = AW'(by_reg) * AW'(BINS) + AW'(bx_reg);
                state_next = S_RD;
            end
            S_RD: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                sum_next   = rd_sum;
                count_next = rd_cnt;
                if (op_reg == OP_HIT && rd_cnt != COUNT_MAX) begin
                    sum_next   = upd_sum;
                    count_next = rd_cnt + 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = addr_reg;
                    mem_wdata  = {count_next, sum_next};
                end
                state_next = S_MSET;
            end
            S_MSET: begin
                if (count_reg <= threshold_reg) begin
                    mean_next  = '0;
                    state_next = S_OUT;
                end else if (sum_reg[SUM_W-1:MEAN_W] >= count_reg) begin
                    // quotient would need more than MEAN_W bits
                    mean_next  = MEAN_MAX;
                    state_next = S_OUT;
                end else begin
                    rem_next     = sum_reg[SUM_W-1:MEAN_W];
                    dvd_next     = sum_reg[MEAN_W-1:0];
                    divisor_next = count_reg;
                    quo_next     = '0;
                    step_next    = STEP_W'(MEAN_W);
                    kind_next    = DK_MEAN;
                    state_next   = S_DIV;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tdata_next = {
                        (M_TDATA_W - 1 - 2*IDX_W - CNT_W - MEAN_W)'(0),
                        ok_reg ? mean_reg : MEAN_W'(0),
                        ok_reg ? count_reg : CNT_W'(0),
                        (ok_reg || op_reg == OP_READ) ? by_reg : IDX_W'(0),
                        (ok_reg || op_reg == OP_READ) ? bx_reg : IDX_W'(0),
                        ok_reg
                    };
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for binned_hit_mean_map: directed edge cases, then random hit/read streams
module tb;
    import bhmm_pkg::*;

    localparam int  BINS        = BINS_DEFAULT;
    localparam int  CELLS       = BINS * BINS;
    localparam int  IDLE_PCT    = 22;
    localparam int  SETTLE_CYC  = 60;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic               in_range;
        logic [IDX_W-1:0]   bin_x;
        logic [IDX_W-1:0]   bin_y;
        logic [CNT_W-1:0]   hit_count;
        logic [MEAN_W-1:0]  mean_amp;
    } bin_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tuser = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor copy of the registers and the bin store
    logic [POS_W-1:0]       cur_origin_x = ORIGIN_RESET;
    logic [POS_W-1:0]       cur_origin_y = ORIGIN_RESET;
    logic [WIDTH_W-1:0]     cur_bin_width = BIN_WIDTH_RESET;
    logic [CNT_W-1:0]       cur_threshold = THRESHOLD_RESET;
    bit   [SUM_W-1:0]       amp_sum_store [CELLS];
    bit   [CNT_W-1:0]       hit_count_store [CELLS];

    bin_result_t            pending_results [$];
    int                     mismatch_cnt = 0;
    longint                 cycle_cnt = 0;
    bit                     steady_flow = 1'b0;

    binned_hit_mean_map #(.BINS(BINS)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic bit axis_index(input logic [POS_W-1:0] pos,
                                      input logic [POS_W-1:0] org,
                                      output logic [IDX_W-1:0] idx);
        longint diff;
        longint q;
        idx = '0;
        diff = longint'($signed(pos)) - longint'($signed(org));
        if (cur_bin_width == 0 || diff < 0)
            return 1'b0;
        q = diff / longint'(cur_bin_width);
        if (q >= BINS)
            return 1'b0;
        idx = q[IDX_W-1:0];
        return 1'b1;
    endfunction

    function automatic logic [MEAN_W-1:0] bin_mean(input int bin_idx);
        longint m;
        if (hit_count_store[bin_idx] == 0 || hit_count_store[bin_idx] <= cur_threshold)
            return '0;
        m = longint'(amp_sum_store[bin_idx]) / longint'(hit_count_store[bin_idx]);
        return (m > MEAN_MAX) ? MEAN_MAX : m[MEAN_W-1:0];
    endfunction

    // bins or reads one item and updates the predicted store
    task automatic predict_bin_result(input op_t op, input logic [POS_W-1:0] px,
                                      input logic [POS_W-1:0] py,
                                      input logic [AMP_W-1:0] amp,
                                      input logic [IDX_W-1:0] rbx,
                                      input logic [IDX_W-1:0] rby,
                                      output bin_result_t res);
        logic [IDX_W-1:0] bx;
        logic [IDX_W-1:0] by;
        bit ok_x;
        bit ok_y;
        bit ok;
        int bin_idx;
        longint total;
        if (op == OP_HIT) begin
            ok_x = axis_index(px, cur_origin_x, bx);
            ok_y = axis_index(py, cur_origin_y, by);
            ok = ok_x && ok_y;
            if (!ok) begin
                bx = '0;
                by = '0;
            end else begin
                bin_idx = int'(by) * BINS + int'(bx);
                if (hit_count_store[bin_idx] < COUNT_MAX) begin
                    total = longint'(amp_sum_store[bin_idx]) + longint'(amp);
                    amp_sum_store[bin_idx] = (total > longint'(SUM_MAX)) ? SUM_MAX
                                                                        : total[SUM_W-1:0];
                    hit_count_store[bin_idx] = hit_count_store[bin_idx] + 1'b1;
                end
            end
        end else begin
            bx = rbx;
            by = rby;
            ok = (int'(bx) < BINS) && (int'(by) < BINS);
        end
        res.in_range = ok;
        res.bin_x = bx;
        res.bin_y = by;
        res.hit_count = '0;
        res.mean_amp = '0;
        if (ok) begin
            bin_idx = int'(by) * BINS + int'(bx);
            res.hit_count = hit_count_store[bin_idx];
            res.mean_amp = bin_mean(bin_idx);
        end
    endtask

    task automatic send_item(input op_t op, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] py, input logic [AMP_W-1:0] amp,
                             input logic [IDX_W-1:0] rbx, input logic [IDX_W-1:0] rby);
        bin_result_t res;
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(S_TDATA_W-66){1'b0}}, rby, rbx, amp, py, px};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_bin_result(op, px, py, amp, rbx, rby, res);
        pending_results.push_back(res);
    endtask

    task automatic send_hit(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input logic [AMP_W-1:0] amp);
        send_item(OP_HIT, px, py, amp, IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic send_read(input int rbx, input int rby);
        send_item(OP_READ, POS_W'($urandom), POS_W'($urandom), AMP_W'($urandom),
                  rbx[IDX_W-1:0], rby[IDX_W-1:0]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_ORIGIN_X:        cur_origin_x = value[POS_W-1:0];
            REG_ORIGIN_Y:        cur_origin_y = value[POS_W-1:0];
            REG_BIN_WIDTH:       cur_bin_width = value[WIDTH_W-1:0];
            REG_COUNT_THRESHOLD: cur_threshold = value[CNT_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_binning(input longint ox, input longint oy, input longint width,
                               input longint thr);
        wait_drained();
        write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox[POS_W-1:0]));
        write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy[POS_W-1:0]));
        write_reg(REG_BIN_WIDTH, CFG_DATA_W'(width[WIDTH_W-1:0]));
        write_reg(REG_COUNT_THRESHOLD, thr[CFG_DATA_W-1:0]);
    endtask

    // position somewhere inside bin b of an axis, wrapped to the port width
    function automatic logic [POS_W-1:0] pos_in_bin(input int b, input logic [POS_W-1:0] org);
        longint p;
        p = longint'($signed(org)) + longint'(b) * longint'(cur_bin_width);
        if (cur_bin_width > 1)
            p = p + longint'($urandom_range(int'(cur_bin_width) - 1));
        return p[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] upper_edge(input logic [POS_W-1:0] org);
        longint p;
        p = longint'($signed(org)) + longint'(BINS) * longint'(cur_bin_width);
        return p[POS_W-1:0];
    endfunction

    always @(posedge aclk) begin
        bin_result_t got;
        bin_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.in_range  = m_tdata[0];
            got.bin_x     = m_tdata[8:1];
            got.bin_y     = m_tdata[16:9];
            got.hit_count = m_tdata[36:17];
            got.mean_amp  = m_tdata[48:37];
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result transfer: tdata=%h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.in_range !== want.in_range || got.bin_x !== want.bin_x
                    || got.bin_y !== want.bin_y || got.hit_count !== want.hit_count
                    || got.mean_amp !== want.mean_amp) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp in=%0d x=%0d y=%0d cnt=%0d mean=%0d, got in=%0d x=%0d y=%0d cnt=%0d mean=%0d",
                                 want.in_range, want.bin_x, want.bin_y, want.hit_count,
                                 want.mean_amp, got.in_range, got.bin_x, got.bin_y,
                                 got.hit_count, got.mean_amp);
                end
            end
        end
        m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // reset registers: grid spans -200000 .. 199999 on both axes
    task automatic test_grid_edges();
        send_hit(-19'sd200000, -19'sd200000, 12'd0);
        send_hit(19'sd199999, 19'sd199999, 12'd4095);
        send_hit(19'sd200000, 19'sd0, 12'd77);
        send_hit(19'sd0, 19'sd200000, 12'd77);
        send_hit(-19'sd200001, 19'sd0, 12'd77);
        send_hit(19'sd0, -19'sd200001, 12'd77);
        send_hit(-19'sd262144, 19'sd262143, 12'd4095);
        send_hit(19'sd199999, -19'sd200000, 12'd2730);
        send_read(0, 0);
        send_read(199, 199);
        send_read(199, 0);
        send_read(200, 0);
        send_read(0, 255);
        send_read(255, 255);
    endtask

    task automatic test_register_extremes();
        set_binning(-200000, -200000, 2000, 0);
        send_read(0, 0);
        send_read(199, 199);
        set_binning(-262144, 262143, 1, 0);
        send_hit(-19'sd262144, 19'sd262143, 12'd1234);
        send_hit(-19'sd261945, 19'sd262143, 12'd2048);
        send_hit(-19'sd261944, 19'sd262143, 12'd5);
        send_read(199, 0);
        set_binning(-262144, -262144, 65535, 1048575);
        send_hit(19'sd262143, 19'sd262143, 12'd100);
        send_read(8, 8);
    endtask

    task automatic test_zero_bin_width();
        set_binning(-200000, -200000, 0, 0);
        send_hit(19'sd0, 19'sd0, 12'd9);
        send_hit(-19'sd200000, -19'sd200000, 12'd9);
        send_read(0, 0);
    endtask

    // mostly hits aimed at a few busy bins so counts pass the threshold,
    // plus noise positions, edge positions and reads of busy and stray bins
    task automatic run_random_traffic(input int n_items, input int n_hot);
        int hot_x [4];
        int hot_y [4];
        int k;
        int r;
        int h;
        for (k = 0; k < 4; k++) begin
            hot_x[k] = $urandom_range(BINS - 1);
            hot_y[k] = $urandom_range(BINS - 1);
        end
        for (k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            h = $urandom_range(n_hot - 1);
            if (r < 65) begin
                if ($urandom_range(9) < 8)
                    send_hit(pos_in_bin(hot_x[h], cur_origin_x),
                             pos_in_bin(hot_y[h], cur_origin_y), AMP_W'($urandom));
                else
                    send_hit(pos_in_bin($urandom_range(BINS - 1), cur_origin_x),
                             pos_in_bin($urandom_range(BINS - 1), cur_origin_y),
                             AMP_W'($urandom));
            end else if (r < 75) begin
                send_hit(POS_W'($urandom), POS_W'($urandom), AMP_W'($urandom));
            end else if (r < 79) begin
                if ($urandom_range(1))
                    send_hit(upper_edge(cur_origin_x), pos_in_bin(hot_y[h], cur_origin_y),
                             AMP_W'($urandom));
                else
                    send_hit(pos_in_bin(hot_x[h], cur_origin_x), cur_origin_y - 1'b1,
                             AMP_W'($urandom));
            end else if (r < 93) begin
                send_read(hot_x[h], hot_y[h]);
            end else if (r < 97) begin
                send_read($urandom_range(BINS - 1), $urandom_range(BINS - 1));
            end else begin
                send_read($urandom_range(255), $urandom_range(255));
            end
        end
    endtask

    task automatic test_random_phases();
        set_binning(-200000, -200000, 2000, 3);
        run_random_traffic(330, 4);
        steady_flow = 1'b1;
        set_binning(0, -300, 1, 0);
        run_random_traffic(330, 4);
        wait_drained();
        steady_flow = 1'b0;
        set_binning(-262144, $urandom_range(524287), 65535, 1048575);
        run_random_traffic(330, 3);
        set_binning($urandom_range(524287), $urandom_range(524287), $urandom_range(65535, 1),
                    $urandom_range(5));
        run_random_traffic(330, 4);
        set_binning(-200000, -200000, 2000, 100);
        run_random_traffic(330, 1);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_grid_edges();
        test_register_extremes();
        test_zero_bin_width();
        test_random_phases();
        wait_drained();
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
